// ----- rtl/ps2_set2_scan_code_key_matrix_macros.svh -----
// Assertion macros shared by the checker of the scan code key matrix.
`ifndef PS2_SET2_SCAN_CODE_KEY_MATRIX_MACROS_SVH
`define PS2_SET2_SCAN_CODE_KEY_MATRIX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PS2S2_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2s2 same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PS2S2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2s2 next-cycle check failed");

`endif

// ----- rtl/ps2s2_pkg.sv -----
package ps2s2_pkg;

  localparam int unsigned MAP_ROWS  = 32;
  localparam int unsigned MAP_BITS  = MAP_ROWS * 8;
  localparam int unsigned POS_W     = $clog2(MAP_BITS);

  // Scan code bytes with a special meaning.
  localparam logic [7:0] CODE_IDLE   = 8'h00;
  localparam logic [7:0] CODE_E0     = 8'hE0;
  localparam logic [7:0] CODE_F0     = 8'hF0;
  localparam logic [7:0] CODE_E1     = 8'hE1;
  localparam logic [7:0] CODE_F7     = 8'h83;
  localparam logic [7:0] CODE_PRSC   = 8'h84;
  localparam logic [7:0] CODE_F5     = 8'h03;
  localparam logic [7:0] CODE_LSHIFT = 8'h12;
  localparam logic [7:0] CODE_RSHIFT = 8'h59;
  localparam logic [7:0] CODE_7E     = 8'h7E;
  localparam logic [7:0] CODE_77     = 8'h77;
  localparam logic [7:0] CODE_14     = 8'h14;

  // Remapped key positions.
  localparam logic [POS_W-1:0] POS_F5    = POS_W'(8'h03);
  localparam logic [POS_W-1:0] POS_F7    = POS_W'(8'h83);
  localparam logic [POS_W-1:0] POS_PRSC  = POS_W'(8'hFC);
  localparam logic [POS_W-1:0] POS_PAUSE = POS_W'(8'hFE);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_F0   = 14'b00000000000010,
    ST_E0   = 14'b00000000000100,
    ST_E0F0 = 14'b00000000001000,
    ST_P1   = 14'b00000000010000,
    ST_P2   = 14'b00000000100000,
    ST_P3   = 14'b00000001000000,
    ST_P4   = 14'b00000010000000,
    ST_P5   = 14'b00000100000000,
    ST_P6   = 14'b00001000000000,
    ST_P7   = 14'b00010000000000,
    ST_C1   = 14'b00100000000000,
    ST_C2   = 14'b01000000000000,
    ST_C3   = 14'b10000000000000
  } parse_state_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_MAKE  = 2'd1,
    ACT_BREAK = 2'd2,
    ACT_CLEAR = 2'd3
  } act_op_e;

  typedef struct packed {
    act_op_e          op;
    logic [POS_W-1:0] pos;
  } act_t;

  typedef struct packed {
    logic             pause_released;
    logic             key_event;
    logic             key_pressed;
    logic [POS_W-1:0] key_position;
    logic             map_cleared;
    logic             changed;
  } res_t;

endpackage

// ----- rtl/ps2s2_ifs.sv -----
interface ps2s2_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2s2_out_if;
  logic       valid;
  logic       ready;
  logic       pause_released;
  logic       key_event;
  logic       key_pressed;
  logic [7:0] key_position;
  logic       map_cleared;
  logic       changed;

  modport source (output valid, output pause_released, output key_event,
                  output key_pressed, output key_position, output map_cleared,
                  output changed, input ready);
  modport sink   (input valid, input pause_released, input key_event,
                  input key_pressed, input key_position, input map_cleared,
                  input changed, output ready);
endinterface

// ----- rtl/ps2_set2_scan_code_key_matrix.sv -----
// Latency: a scan byte accepted at a clock edge gives its result beat from the next cycle.
// Throughput: one byte per cycle while the result buffer has room; the key map update is a single register pass.
// A two-entry result buffer lets input beats keep flowing while one result waits.
// Reset (rst_ni low, asynchronous) puts the parser in idle, clears all 256 key
// bits and empties the result buffer; it takes effect at once, with no clearing pass.
module ps2_set2_scan_code_key_matrix (
  input logic         clk_i,
  input logic         rst_ni,
  ps2s2_in_if.sink    scan_i,
  ps2s2_out_if.source result_o
);

  logic            accept;
  logic            buf_ready;
  ps2s2_pkg::act_t act;
  ps2s2_pkg::res_t res;
  ps2s2_pkg::res_t res_out;

  assign scan_i.ready = buf_ready;
  assign accept       = scan_i.valid && buf_ready;

  ps2s2_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .scan_byte_i (scan_i.scan_byte),
    .act_o       (act)
  );

  ps2s2_keymap u_keymap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .act_i    (act),
    .res_o    (res)
  );

  ps2s2_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (res),
    .ready_o     (buf_ready),
    .valid_o     (result_o.valid),
    .pop_ready_i (result_o.ready),
    .data_o      (res_out)
  );

  assign result_o.pause_released = res_out.pause_released;
  assign result_o.key_event      = res_out.key_event;
  assign result_o.key_pressed    = res_out.key_pressed;
  assign result_o.key_position   = res_out.key_position;
  assign result_o.map_cleared    = res_out.map_cleared;
  assign result_o.changed        = res_out.changed;

endmodule

// ----- rtl/ps2s2_parser.sv -----
module ps2s2_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        scan_byte_i,
  output ps2s2_pkg::act_t   act_o
);

  ps2s2_pkg::parse_state_e state_q, state_d;
  ps2s2_pkg::act_t         act;
  logic [7:0]              c;

  assign c = scan_byte_i;

  always_comb begin
    state_d  = ps2s2_pkg::ST_IDLE;
    act.op   = ps2s2_pkg::ACT_NONE;
    act.pos  = '0;
    if (c == ps2s2_pkg::CODE_IDLE) begin
      // An idle poll leaves the parser where it is.
      state_d = state_q;
    end else begin
      case (state_q)
        ps2s2_pkg::ST_IDLE: begin
          if (c == ps2s2_pkg::CODE_E0) begin
            state_d = ps2s2_pkg::ST_E0;
          end else if (c == ps2s2_pkg::CODE_F0) begin
            state_d = ps2s2_pkg::ST_F0;
          end else if (c == ps2s2_pkg::CODE_E1) begin
            state_d = ps2s2_pkg::ST_P1;
          end else if (c == ps2s2_pkg::CODE_F7) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = ps2s2_pkg::POS_F7;
          end else if (c == ps2s2_pkg::CODE_PRSC) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = ps2s2_pkg::POS_PRSC;
          end else if (!c[7]) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = c;
          end else begin
            act.op  = ps2s2_pkg::ACT_CLEAR;
          end
        end
        ps2s2_pkg::ST_E0: begin
          if (c inside {ps2s2_pkg::CODE_LSHIFT, ps2s2_pkg::CODE_RSHIFT}) begin
            // Fake shift codes are dropped.
          end else if (c == ps2s2_pkg::CODE_7E) begin
            state_d = ps2s2_pkg::ST_C1;
          end else if (c == ps2s2_pkg::CODE_F0) begin
            state_d = ps2s2_pkg::ST_E0F0;
          end else if (c == ps2s2_pkg::CODE_F7) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = ps2s2_pkg::POS_F7;
          end else if (c == ps2s2_pkg::CODE_F5) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = ps2s2_pkg::POS_F5;
          end else if (!c[7]) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = {1'b1, c[6:0]};
          end else begin
            act.op  = ps2s2_pkg::ACT_CLEAR;
          end
        end
        ps2s2_pkg::ST_F0: begin
          if (c == ps2s2_pkg::CODE_F7) begin
            act.op  = ps2s2_pkg::ACT_BREAK;
            act.pos = ps2s2_pkg::POS_F7;
          end else if (c == ps2s2_pkg::CODE_PRSC) begin
            act.op  = ps2s2_pkg::ACT_BREAK;
            act.pos = ps2s2_pkg::POS_PRSC;
          end else if (c == ps2s2_pkg::CODE_F0) begin
            // A doubled break prefix clears the map but keeps the break state.
            act.op  = ps2s2_pkg::ACT_CLEAR;
            state_d = ps2s2_pkg::ST_F0;
          end else if (!c[7]) begin
            act.op  = ps2s2_pkg::ACT_BREAK;
            act.pos = c;
          end else begin
            act.op  = ps2s2_pkg::ACT_CLEAR;
          end
        end
        ps2s2_pkg::ST_E0F0: begin
          if (c inside {ps2s2_pkg::CODE_LSHIFT, ps2s2_pkg::CODE_RSHIFT}) begin
            // Fake shift codes are dropped.
          end else if (c == ps2s2_pkg::CODE_F7) begin
            act.op  = ps2s2_pkg::ACT_BREAK;
            act.pos = ps2s2_pkg::POS_F7;
          end else if (c == ps2s2_pkg::CODE_F5) begin
            act.op  = ps2s2_pkg::ACT_BREAK;
            act.pos = ps2s2_pkg::POS_F5;
          end else if (!c[7]) begin
            act.op  = ps2s2_pkg::ACT_BREAK;
            act.pos = {1'b1, c[6:0]};
          end else begin
            act.op  = ps2s2_pkg::ACT_CLEAR;
          end
        end
        ps2s2_pkg::ST_P1: if (c == ps2s2_pkg::CODE_14) state_d = ps2s2_pkg::ST_P2;
        ps2s2_pkg::ST_P2: if (c == ps2s2_pkg::CODE_77) state_d = ps2s2_pkg::ST_P3;
        ps2s2_pkg::ST_P3: if (c == ps2s2_pkg::CODE_E1) state_d = ps2s2_pkg::ST_P4;
        ps2s2_pkg::ST_P4: if (c == ps2s2_pkg::CODE_F0) state_d = ps2s2_pkg::ST_P5;
        ps2s2_pkg::ST_P5: if (c == ps2s2_pkg::CODE_14) state_d = ps2s2_pkg::ST_P6;
        ps2s2_pkg::ST_P6: if (c == ps2s2_pkg::CODE_F0) state_d = ps2s2_pkg::ST_P7;
        ps2s2_pkg::ST_P7: begin
          if (c == ps2s2_pkg::CODE_77) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = ps2s2_pkg::POS_PAUSE;
          end
        end
        ps2s2_pkg::ST_C1: if (c == ps2s2_pkg::CODE_E0) state_d = ps2s2_pkg::ST_C2;
        ps2s2_pkg::ST_C2: if (c == ps2s2_pkg::CODE_F0) state_d = ps2s2_pkg::ST_C3;
        ps2s2_pkg::ST_C3: begin
          if (c == ps2s2_pkg::CODE_7E) begin
            act.op  = ps2s2_pkg::ACT_MAKE;
            act.pos = ps2s2_pkg::POS_PAUSE;
          end
        end
        default: state_d = ps2s2_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ps2s2_pkg::ST_IDLE;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  assign act_o = act;

endmodule

// ----- rtl/ps2s2_keymap.sv -----
module ps2s2_keymap (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  ps2s2_pkg::act_t act_i,
  output ps2s2_pkg::res_t res_o
);

  logic [ps2s2_pkg::MAP_BITS-1:0] map_q, map_d, map_rel;
  logic                           pause_held;
  logic                           key_bit;
  ps2s2_pkg::res_t                res;

  always_comb begin
    // A held Pause is released before the byte itself is looked at.
    pause_held                      = map_q[ps2s2_pkg::POS_PAUSE];
    map_rel                         = map_q;
    map_rel[ps2s2_pkg::POS_PAUSE]   = 1'b0;
    key_bit                         = map_rel[act_i.pos];
    map_d                           = map_rel;

    res.pause_released = pause_held;
    res.key_event      = 1'b0;
    res.key_pressed    = 1'b0;
    res.key_position   = '0;
    res.map_cleared    = 1'b0;

    case (act_i.op)
      ps2s2_pkg::ACT_MAKE: begin
        if (!key_bit) begin
          map_d[act_i.pos]  = 1'b1;
          res.key_event     = 1'b1;
          res.key_pressed   = 1'b1;
          res.key_position  = act_i.pos;
        end
      end
      ps2s2_pkg::ACT_BREAK: begin
        if (key_bit) begin
          map_d[act_i.pos]  = 1'b0;
          res.key_event     = 1'b1;
          res.key_position  = act_i.pos;
        end
      end
      ps2s2_pkg::ACT_CLEAR: begin
        map_d           = '0;
        res.map_cleared = 1'b1;
      end
      default: ;
    endcase

    res.changed = res.pause_released | res.key_event;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else if (accept_i) begin
      map_q <= map_d;
    end
  end

  assign res_o = res;

endmodule

// ----- rtl/ps2s2_skid.sv -----
module ps2s2_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ps2s2_pkg::res_t data_i,
  output logic            ready_o,
  output logic            valid_o,
  input  logic            pop_ready_i,
  output ps2s2_pkg::res_t data_o
);

  ps2s2_pkg::res_t entry_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/ps2s2_checker.sv -----
`include "ps2_set2_scan_code_key_matrix_macros.svh"

module ps2s2_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       pause_released_i,
  input logic       key_event_i,
  input logic       key_pressed_i,
  input logic [7:0] key_position_i,
  input logic       map_cleared_i,
  input logic       changed_i
);

  logic [12:0] beat_fields;
  logic        changed_ok;
  logic        quiet_ok;

  assign beat_fields = {pause_released_i, key_event_i, key_pressed_i, key_position_i,
                        map_cleared_i, changed_i};
  assign changed_ok  = (changed_i == (pause_released_i | key_event_i));
  assign quiet_ok    = !key_pressed_i && (key_position_i == 8'd0);

  // The change flag is exactly the union of a Pause release and a key event.
  `PS2S2_ASSERT_SAME(a_changed_union, out_valid_i, changed_ok)

  // Without a key event the make flag and position read as zero.
  `PS2S2_ASSERT_SAME(a_quiet_fields, out_valid_i && !key_event_i, quiet_ok)

  // A map clear never reports a key event in the same beat.
  `PS2S2_ASSERT_SAME(a_clear_no_event, out_valid_i && map_cleared_i, !key_event_i)

  // A stalled result beat stays put.
  `PS2S2_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(beat_fields))

endmodule

bind ps2_set2_scan_code_key_matrix ps2s2_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .pause_released_i (result_o.pause_released),
  .key_event_i      (result_o.key_event),
  .key_pressed_i    (result_o.key_pressed),
  .key_position_i   (result_o.key_position),
  .map_cleared_i    (result_o.map_cleared),
  .changed_i        (result_o.changed)
);

// ----- verif/tb.sv -----
module tb;

  logic clk_i;
  logic rst_ni;

  ps2s2_in_if  scan_if ();
  ps2s2_out_if res_if ();

  ps2_set2_scan_code_key_matrix dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scan_i   (scan_if),
    .result_o (res_if)
  );

  // Model of the decoder: parser state and the pressed-key map.
  ps2s2_pkg::parse_state_e        parser_st;
  logic [ps2s2_pkg::MAP_BITS-1:0] pressed_map;

  ps2s2_pkg::res_t key_reports_q[$];
  int unsigned     mismatches;
  int unsigned     bytes_sent;
  bit              idling_on;

  always #1 clk_i = ~clk_i;

  function automatic void press_key(input logic [7:0] pos, inout ps2s2_pkg::res_t r);
    if (!pressed_map[pos]) begin
      pressed_map[pos] = 1'b1;
      r.key_event      = 1'b1;
      r.key_pressed    = 1'b1;
      r.key_position   = pos;
    end
  endfunction

  function automatic void release_key(input logic [7:0] pos, inout ps2s2_pkg::res_t r);
    if (pressed_map[pos]) begin
      pressed_map[pos] = 1'b0;
      r.key_event      = 1'b1;
      r.key_pressed    = 1'b0;
      r.key_position   = pos;
    end
  endfunction

  function automatic void clear_map(inout ps2s2_pkg::res_t r);
    pressed_map   = '0;
    r.map_cleared = 1'b1;
  endfunction

  function automatic ps2s2_pkg::res_t decode_scan_byte(input logic [7:0] c);
    ps2s2_pkg::res_t         r;
    ps2s2_pkg::parse_state_e nxt;
    r   = '0;
    nxt = ps2s2_pkg::ST_IDLE;
    // Pause has no break code, so a held Pause is dropped by whatever byte comes next.
    if (pressed_map[ps2s2_pkg::POS_PAUSE]) begin
      pressed_map[ps2s2_pkg::POS_PAUSE] = 1'b0;
      r.pause_released                  = 1'b1;
    end
    if (c != ps2s2_pkg::CODE_IDLE) begin
      case (parser_st)
        ps2s2_pkg::ST_IDLE: begin
          if (c == ps2s2_pkg::CODE_E0) nxt = ps2s2_pkg::ST_E0;
          else if (c == ps2s2_pkg::CODE_F0) nxt = ps2s2_pkg::ST_F0;
          else if (c == ps2s2_pkg::CODE_E1) nxt = ps2s2_pkg::ST_P1;
          else if (c == ps2s2_pkg::CODE_F7) press_key(ps2s2_pkg::POS_F7, r);
          else if (c == ps2s2_pkg::CODE_PRSC) press_key(ps2s2_pkg::POS_PRSC, r);
          else if (!c[7]) press_key(c, r);
          else clear_map(r);
        end
        ps2s2_pkg::ST_E0: begin
          if (c == ps2s2_pkg::CODE_LSHIFT || c == ps2s2_pkg::CODE_RSHIFT) begin
            nxt = ps2s2_pkg::ST_IDLE;
          end
          else if (c == ps2s2_pkg::CODE_7E) nxt = ps2s2_pkg::ST_C1;
          else if (c == ps2s2_pkg::CODE_F0) nxt = ps2s2_pkg::ST_E0F0;
          else if (c == ps2s2_pkg::CODE_F7) press_key(ps2s2_pkg::POS_F7, r);
          else if (c == ps2s2_pkg::CODE_F5) press_key(ps2s2_pkg::POS_F5, r);
          else if (!c[7]) press_key(c | 8'h80, r);
          else clear_map(r);
        end
        ps2s2_pkg::ST_F0: begin
          if (c == ps2s2_pkg::CODE_F7) release_key(ps2s2_pkg::POS_F7, r);
          else if (c == ps2s2_pkg::CODE_PRSC) release_key(ps2s2_pkg::POS_PRSC, r);
          else if (c == ps2s2_pkg::CODE_F0) begin
            clear_map(r);
            nxt = ps2s2_pkg::ST_F0;
          end
          else if (!c[7]) release_key(c, r);
          else clear_map(r);
        end
        ps2s2_pkg::ST_E0F0: begin
          if (c == ps2s2_pkg::CODE_LSHIFT || c == ps2s2_pkg::CODE_RSHIFT) begin
            nxt = ps2s2_pkg::ST_IDLE;
          end
          else if (c == ps2s2_pkg::CODE_F7) release_key(ps2s2_pkg::POS_F7, r);
          else if (c == ps2s2_pkg::CODE_F5) release_key(ps2s2_pkg::POS_F5, r);
          else if (!c[7]) release_key(c | 8'h80, r);
          else clear_map(r);
        end
        ps2s2_pkg::ST_P1: if (c == ps2s2_pkg::CODE_14) nxt = ps2s2_pkg::ST_P2;
        ps2s2_pkg::ST_P2: if (c == ps2s2_pkg::CODE_77) nxt = ps2s2_pkg::ST_P3;
        ps2s2_pkg::ST_P3: if (c == ps2s2_pkg::CODE_E1) nxt = ps2s2_pkg::ST_P4;
        ps2s2_pkg::ST_P4: if (c == ps2s2_pkg::CODE_F0) nxt = ps2s2_pkg::ST_P5;
        ps2s2_pkg::ST_P5: if (c == ps2s2_pkg::CODE_14) nxt = ps2s2_pkg::ST_P6;
        ps2s2_pkg::ST_P6: if (c == ps2s2_pkg::CODE_F0) nxt = ps2s2_pkg::ST_P7;
        ps2s2_pkg::ST_P7: if (c == ps2s2_pkg::CODE_77) press_key(ps2s2_pkg::POS_PAUSE, r);
        ps2s2_pkg::ST_C1: if (c == ps2s2_pkg::CODE_E0) nxt = ps2s2_pkg::ST_C2;
        ps2s2_pkg::ST_C2: if (c == ps2s2_pkg::CODE_F0) nxt = ps2s2_pkg::ST_C3;
        ps2s2_pkg::ST_C3: if (c == ps2s2_pkg::CODE_7E) press_key(ps2s2_pkg::POS_PAUSE, r);
        default: nxt = ps2s2_pkg::ST_IDLE;
      endcase
      parser_st = nxt;
    end
    r.changed = r.pause_released | r.key_event;
    return r;
  endfunction

  function automatic string report_str(input ps2s2_pkg::res_t r);
    return $sformatf("prel=%0b ev=%0b pressed=%0b pos=%02h cleared=%0b changed=%0b",
                     r.pause_released, r.key_event, r.key_pressed, r.key_position,
                     r.map_cleared, r.changed);
  endfunction

  task automatic send_scan_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (idling_on && $urandom_range(99) < 38) begin
      scan_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    scan_if.valid     <= 1'b1;
    scan_if.scan_byte <= b;
    do @(posedge clk_i); while (!scan_if.ready);
    key_reports_q.push_back(decode_scan_byte(b));
    bytes_sent++;
  endtask

  // Half the codes come from a small pool so that breaks often find their key held.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(1)) return 8'($urandom_range(8'h17, 8'h10));
    return 8'($urandom_range(8'h7F, 8'h01));
  endfunction

  task automatic run_random_bytes(input int unsigned n_bytes);
    logic [7:0]  pause_e1[8] = '{ps2s2_pkg::CODE_E1, ps2s2_pkg::CODE_14, ps2s2_pkg::CODE_77,
                                 ps2s2_pkg::CODE_E1, ps2s2_pkg::CODE_F0, ps2s2_pkg::CODE_14,
                                 ps2s2_pkg::CODE_F0, ps2s2_pkg::CODE_77};
    logic [7:0]  pause_e0[5] = '{ps2s2_pkg::CODE_E0, ps2s2_pkg::CODE_7E, ps2s2_pkg::CODE_E0,
                                 ps2s2_pkg::CODE_F0, ps2s2_pkg::CODE_7E};
    int unsigned target;
    int unsigned kind;
    int unsigned cut;
    logic [7:0]  code;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      kind = $urandom_range(99);
      code = pick_code();
      if (kind < 25) begin
        send_scan_byte(code);
      end else if (kind < 45) begin
        send_scan_byte(ps2s2_pkg::CODE_F0);
        send_scan_byte(code);
      end else if (kind < 57) begin
        send_scan_byte(ps2s2_pkg::CODE_E0);
        send_scan_byte(code);
      end else if (kind < 67) begin
        send_scan_byte(ps2s2_pkg::CODE_E0);
        send_scan_byte(ps2s2_pkg::CODE_F0);
        send_scan_byte(code);
      end else if (kind < 72) begin
        if ($urandom_range(1)) send_scan_byte(ps2s2_pkg::CODE_F0);
        send_scan_byte($urandom_range(1) ? ps2s2_pkg::CODE_F7 : ps2s2_pkg::CODE_PRSC);
      end else if (kind < 76) begin
        foreach (pause_e1[i]) send_scan_byte(pause_e1[i]);
      end else if (kind < 80) begin
        foreach (pause_e0[i]) send_scan_byte(pause_e0[i]);
      end else if (kind < 85) begin
        // A Pause sequence cut short by an arbitrary byte.
        if ($urandom_range(1)) begin
          cut = $urandom_range(7, 1);
          for (int i = 0; i < cut; i++) send_scan_byte(pause_e1[i]);
        end else begin
          cut = $urandom_range(4, 1);
          for (int i = 0; i < cut; i++) send_scan_byte(pause_e0[i]);
        end
        send_scan_byte(8'($urandom_range(255)));
      end else if (kind < 90) begin
        send_scan_byte(ps2s2_pkg::CODE_IDLE);
      end else begin
        send_scan_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_directed();
    logic [7:0] bytes[29] = '{
      ps2s2_pkg::CODE_IDLE, 8'h1C, 8'h7F, ps2s2_pkg::CODE_F0, 8'h1C, ps2s2_pkg::CODE_E0,
      ps2s2_pkg::CODE_F5, ps2s2_pkg::CODE_E0, ps2s2_pkg::CODE_F0,
      ps2s2_pkg::CODE_RSHIFT, ps2s2_pkg::CODE_PRSC, ps2s2_pkg::CODE_F0, ps2s2_pkg::CODE_F0,
      8'h7F,
      ps2s2_pkg::CODE_E1, ps2s2_pkg::CODE_14, ps2s2_pkg::CODE_77, ps2s2_pkg::CODE_E1,
      ps2s2_pkg::CODE_F0, ps2s2_pkg::CODE_14, ps2s2_pkg::CODE_F0, ps2s2_pkg::CODE_77,
      ps2s2_pkg::CODE_IDLE,
      ps2s2_pkg::CODE_E0, ps2s2_pkg::CODE_7E, ps2s2_pkg::CODE_E0, ps2s2_pkg::CODE_F0,
      ps2s2_pkg::CODE_7E, 8'hFF
    };
    foreach (bytes[i]) send_scan_byte(bytes[i]);
  endtask

  task automatic test_random_idling();
    idling_on = 1'b1;
    run_random_bytes(350);
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    run_random_bytes(300);
    idling_on = 1'b1;
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= !idling_on || ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin : check_reports
    ps2s2_pkg::res_t got;
    ps2s2_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.pause_released, res_if.key_event, res_if.key_pressed,
             res_if.key_position, res_if.map_cleared, res_if.changed};
      if (key_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report beat: %s", report_str(got));
      end else begin
        want = key_reports_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch: expected %s", report_str(want));
            $display("                 actual   %s", report_str(got));
          end
        end
      end
    end
  end

  initial begin
    #400000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    scan_if.valid     = 1'b0;
    scan_if.scan_byte = ps2s2_pkg::CODE_IDLE;
    res_if.ready      = 1'b0;
    parser_st         = ps2s2_pkg::ST_IDLE;
    pressed_map       = '0;
    mismatches        = 0;
    bytes_sent        = 0;
    idling_on         = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_idling();
    test_back_to_back();
    test_random_idling();

    @(negedge clk_i);
    scan_if.valid <= 1'b0;
    while (key_reports_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && key_reports_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ps2s2_pkg.sv
rtl/ps2s2_ifs.sv
rtl/ps2s2_parser.sv
rtl/ps2s2_keymap.sv
rtl/ps2s2_skid.sv
rtl/ps2_set2_scan_code_key_matrix.sv
rtl/ps2s2_checker.sv
verif/tb.sv
